// ===== design/amd_pkg.sv =====
// Shared types and constants for the adjacency matrix max-degree block.
// Used by the stream interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package amd_pkg;

  localparam int MAX_VERTICES = 32;
  // Row address width and width of a degree count.
  localparam int ROW_AW = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  // Vertex fields and the vertex count register are fixed at six bits.
  localparam int VTX_W  = 6;
  // Width used for vertex numbers, counters and compares inside the block.
  localparam int N_W    = (CNT_W > VTX_W) ? CNT_W : VTX_W;

  localparam logic [VTX_W-1:0] CFG_RESET = 6'd32;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_MAXDEG = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_QUERY   = 2'd0,
    KIND_MAXDEG  = 2'd1,
    KIND_INVALID = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             joined;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] degree;
    logic             last;
  } out_item_t;

endpackage

// ===== design/amd_in_if.sv =====
// Input stream interface: valid, ready and one command item.
// Depends on amd_pkg.
`timescale 1ns / 1ps

interface amd_in_if;
  import amd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/amd_out_if.sv =====
// Output stream interface: valid, ready and one result item.
// Depends on amd_pkg.
`timescale 1ns / 1ps

interface amd_out_if;
  import amd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/amd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module amd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/adjacency_matrix_max_degree.sv =====
// Adjacency matrix max-degree block: top level with sequencer and row RAM.
// Depends on amd_pkg, amd_in_if, amd_out_if and amd_ram.
`timescale 1ns / 1ps

// Keeps an undirected graph as one row of bits per vertex in a synchronous RAM;
// rows that were never written read as zero through per-row valid flops, so the
// matrix is empty right after reset with no clearing pass. Each item is handled
// alone by a read-modify-write sequencer on the single RAM read port. Add edge
// reads and writes each mirror row in turn and gives no result. Query reads the
// first vertex's row and tests the second vertex's bit. Max degree streams all n
// rows once to find the best count, then rescans up to the last matching vertex,
// one row per cycle while no match is found; each emitted vertex waits in S_PUT
// until the output register is free. Results sit in an output register, so a new
// item is taken while the last result waits.

module adjacency_matrix_max_degree (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [amd_pkg::VTX_W-1:0] cfg_wdata_i,
  amd_in_if.sink                    in_i,
  amd_out_if.source                 out_o
);
  import amd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ADD_A    = 8'b0000_0010,
    S_ADD_B_RD = 8'b0000_0100,
    S_ADD_B    = 8'b0000_1000,
    S_QUERY    = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_EMIT     = 8'b0100_0000,
    S_PUT      = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [VTX_W-1:0]  cfg_q;
  logic [N_W-1:0]    n_eff;
  row_t              act_mask;

  logic [VTX_W-1:0]  a_q, a_d, b_q, b_d;
  logic [N_W-1:0]    v_q, v_d, best_q, best_d, lastv_q, lastv_d;
  logic [N_W-1:0]    scan_idx_q, scan_idx_d;
  logic              scan_vld_q, scan_vld_d;
  out_item_t         res_q, res_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;
  logic              slot_free;

  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  row_t              ram_wdata, ram_rdata, rd_row;
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic              rd_vld_q;
  logic [N_W-1:0]    deg;

  logic [VTX_W-1:0]  in_a_m1, a_m1, b_m1;
  logic              in_bad;
  logic [N_W-1:0]    v_inc;

  amd_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clamp the vertex count into 1..MAX_VERTICES.
  always_comb begin
    n_eff = N_W'(cfg_q);
    if (n_eff == '0) begin
      n_eff = N_W'(1);
    end else if (n_eff > N_W'(MAX_VERTICES)) begin
      n_eff = N_W'(MAX_VERTICES);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act_mask[i] = (N_W'(i) < n_eff);
    end
  end

  assign rd_row    = rd_vld_q ? ram_rdata : '0;
  assign deg       = N_W'($countones(rd_row & act_mask));
  assign slot_free = !out_valid_q || out_o.ready;
  assign v_inc     = v_q + N_W'(1);

  assign in_a_m1 = in_i.data.first_vertex - VTX_W'(1);
  assign a_m1    = a_q - VTX_W'(1);
  assign b_m1    = b_q - VTX_W'(1);
  assign in_bad  = (in_i.data.first_vertex == '0) || (in_i.data.second_vertex == '0) ||
                   (N_W'(in_i.data.first_vertex) > n_eff) ||
                   (N_W'(in_i.data.second_vertex) > n_eff);

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    v_d         = v_q;
    best_d      = best_q;
    lastv_d     = lastv_q;
    scan_idx_d  = scan_idx_q;
    scan_vld_d  = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = a_m1[ROW_AW-1:0];
    ram_wdata   = rd_row;
    ram_re      = 1'b0;
    ram_raddr   = v_q[ROW_AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          a_d = in_i.data.first_vertex;
          b_d = in_i.data.second_vertex;
          unique case (in_i.data.opcode)
            OP_ADD, OP_QUERY: begin
              if (in_bad) begin
                res_d   = '{kind: KIND_INVALID, joined: 1'b0, vertex: '0,
                            degree: '0, last: 1'b1};
                state_d = S_PUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = in_a_m1[ROW_AW-1:0];
                state_d   = (in_i.data.opcode == OP_ADD) ? S_ADD_A : S_QUERY;
              end
            end
            OP_MAXDEG: begin
              v_d     = '0;
              best_d  = '0;
              lastv_d = '0;
              state_d = S_SCAN;
            end
            default: begin
              // unused opcode: drop the item
            end
          endcase
        end
      end

      S_ADD_A: begin
        ram_we    = 1'b1;
        ram_waddr = a_m1[ROW_AW-1:0];
        ram_wdata = rd_row | (row_t'(1) << b_m1[ROW_AW-1:0]);
        state_d   = S_ADD_B_RD;
      end

      S_ADD_B_RD: begin
        // read after the first write lands, so a self loop sees its own bit
        ram_re    = 1'b1;
        ram_raddr = b_m1[ROW_AW-1:0];
        state_d   = S_ADD_B;
      end

      S_ADD_B: begin
        ram_we    = 1'b1;
        ram_waddr = b_m1[ROW_AW-1:0];
        ram_wdata = rd_row | (row_t'(1) << a_m1[ROW_AW-1:0]);
        state_d   = S_IDLE;
      end

      S_QUERY: begin
        res_d   = '{kind: KIND_QUERY, joined: rd_row[b_m1[ROW_AW-1:0]], vertex: '0,
                    degree: '0, last: 1'b1};
        state_d = S_PUT;
      end

      S_SCAN: begin
        if (v_q < n_eff) begin
          ram_re     = 1'b1;
          ram_raddr  = v_q[ROW_AW-1:0];
          scan_idx_d = v_q;
          scan_vld_d = 1'b1;
          v_d        = v_inc;
        end
        if (scan_vld_q) begin
          // ties move the last marker forward
          if (deg >= best_q) begin
            best_d  = deg;
            lastv_d = scan_idx_q;
          end
        end else if (v_q == n_eff) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          v_d       = '0;
          state_d   = S_EMIT;
        end
      end

      S_EMIT: begin
        if (deg == best_q) begin
          res_d   = '{kind: KIND_MAXDEG, joined: 1'b0, vertex: v_inc[VTX_W-1:0],
                      degree: best_q[VTX_W-1:0], last: (v_q == lastv_q)};
          state_d = S_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = v_inc[ROW_AW-1:0];
          v_d       = v_inc;
        end
      end

      S_PUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          if (res_q.last) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = v_inc[ROW_AW-1:0];
            v_d       = v_inc;
            state_d   = S_EMIT;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      scan_vld_q  <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scan_vld_q  <= scan_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (ram_re) begin
        rd_vld_q <= row_vld_q[ram_raddr];
      end
      if (ram_we) begin
        row_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    v_q        <= v_d;
    best_q     <= best_d;
    lastv_q    <= lastv_d;
    scan_idx_q <= scan_idx_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  // A row read never lines up with a write to the same row.
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row read and write collide");

  // The best degree never exceeds the number of vertices in use.
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (best_q <= n_eff))
    else $error("best degree out of range");

  // The emit pass never runs past the last matching vertex.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (v_q <= lastv_q))
    else $error("emit pass ran past the last match");

  // Handing off a final result returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && slot_free && res_q.last) |=> (state_q == S_IDLE))
    else $error("final result did not end the item");
`endif

endmodule

// ===== tb/amd_result_checker.sv =====
// Result checker for the adjacency matrix max-degree block: keeps its own copy of
// the graph and the vertex count, predicts every result and compares it on arrival.
// Depends on amd_pkg, amd_in_if and amd_out_if.
`timescale 1ns / 1ps

module amd_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [amd_pkg::VTX_W-1:0] cfg_wdata_i,
  amd_in_if                         cmd_i,
  amd_out_if                        res_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);
  import amd_pkg::*;

  row_t             adj_rows [MAX_VERTICES];
  logic [VTX_W-1:0] vtx_limit;
  out_item_t        expected_results [$];
  int               fails = 0;
  int               waiting = 0;
  int               checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;
  assign checked_o    = checked;

  task automatic report_mismatch(input string what, input int got, input int want);
    fails++;
    $display("%0t ns: %s: got %0d, wanted %0d", $time, what, got, want);
  endtask

  // A count of zero acts as one, anything above the matrix size as the full size.
  function automatic int active_vertices();
    if (vtx_limit == 0) return 1;
    if (vtx_limit > MAX_VERTICES) return MAX_VERTICES;
    return vtx_limit;
  endfunction

  task automatic push_result(input kind_e k, input logic j, input int v, input int d,
                             input logic l);
    out_item_t r;
    r.kind   = k;
    r.joined = j;
    r.vertex = v[VTX_W-1:0];
    r.degree = d[VTX_W-1:0];
    r.last   = l;
    expected_results.push_back(r);
  endtask

  task automatic predict_graph_op(input in_item_t item);
    int   n;
    int   a;
    int   b;
    int   best;
    int   lastv;
    int   d;
    row_t mask;
    n = active_vertices();
    a = item.first_vertex;
    b = item.second_vertex;
    mask = '0;
    for (int v = 0; v < n; v++) mask[v] = 1'b1;
    case (item.opcode)
      OP_ADD, OP_QUERY: begin
        if (a == 0 || a > n || b == 0 || b > n) begin
          push_result(KIND_INVALID, 1'b0, 0, 0, 1'b1);
        end else if (item.opcode == OP_ADD) begin
          adj_rows[a-1][b-1] = 1'b1;
          adj_rows[b-1][a-1] = 1'b1;
        end else begin
          push_result(KIND_QUERY, adj_rows[a-1][b-1], 0, 0, 1'b1);
        end
      end
      OP_MAXDEG: begin
        best  = 0;
        lastv = 0;
        for (int v = 0; v < n; v++) begin
          d = $countones(adj_rows[v] & mask);
          if (d > best) best = d;
        end
        for (int v = 0; v < n; v++) begin
          if ($countones(adj_rows[v] & mask) == best) lastv = v;
        end
        for (int v = 0; v < n; v++) begin
          if ($countones(adj_rows[v] & mask) == best) begin
            push_result(KIND_MAXDEG, 1'b0, v + 1, best, v == lastv);
          end
        end
      end
      default: ;  // drop the unused opcode
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    checked++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending, kind", got.kind, -1);
      return;
    end
    want = expected_results.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.joined !== want.joined) report_mismatch("joined", got.joined, want.joined);
    if (got.vertex !== want.vertex) report_mismatch("vertex", got.vertex, want.vertex);
    if (got.degree !== want.degree) report_mismatch("degree", got.degree, want.degree);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  // Retire results before predicting, so a result arriving with nothing pending is caught.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vtx_limit = CFG_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we_i) vtx_limit = cfg_wdata_i;
      if (res_i.valid && res_i.ready) check_result(res_i.data);
      if (cmd_i.valid && cmd_i.ready) predict_graph_op(cmd_i.data);
    end
    waiting <= expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the adjacency matrix max-degree testbench: clock, reset, commands, result
// stalls, vertex-count writes and the verdict. Depends on amd_pkg, both stream
// interfaces, the block and amd_result_checker.
`timescale 1ns / 1ps

module testbench;
  import amd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         SETTLE      = 40;   // covers an add edge still in flight
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 4000;
  localparam int         PHASE_ITEMS = 50;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [VTX_W-1:0] cfg_wdata;
  int               fails;
  int               pending;
  int               checked;
  int               commands_sent = 0;
  int               settings_used = 0;
  int               cur_n = MAX_VERTICES;
  bit               send_burst = 1'b0;
  bit               recv_burst = 1'b0;
  bit               long_hold = 1'b0;

  amd_in_if  cmd_if ();
  amd_out_if res_if ();

  adjacency_matrix_max_degree dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (cmd_if),
    .out_o       (res_if)
  );

  amd_result_checker result_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #1 clk = ~clk;

  function automatic int pick_pause(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_cmd(input logic [1:0] op, input int a, input int b);
    in_item_t item;
    int       pause;
    item.opcode        = op;
    item.first_vertex  = a[VTX_W-1:0];
    item.second_vertex = b[VTX_W-1:0];
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    pause = pick_pause(send_burst);
    if (pause > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    cmd_if.data  <= item;
    cmd_if.valid <= 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    if (op != OP_UNUSED) commands_sent++;
  endtask

  // Mostly well-formed vertex pairs; a few raw six-bit values and unused opcodes.
  task automatic send_random();
    int         r;
    int         a;
    int         b;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    a = $urandom_range(1, cur_n);
    b = $urandom_range(1, cur_n);
    if (r < 3) begin
      op = OP_UNUSED;
      a  = $urandom_range(0, 63);
      b  = $urandom_range(0, 63);
    end else if (r < 50) begin
      op = OP_ADD;
    end else if (r < 82) begin
      op = OP_QUERY;
    end else begin
      op = OP_MAXDEG;
      a  = $urandom_range(0, 63);
      b  = $urandom_range(0, 63);
    end
    if ((op == OP_ADD || op == OP_QUERY) && $urandom_range(0, 99) < 8) begin
      a = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
    end
    send_cmd(op, a, b);
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_wdata <= v[VTX_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    v = v & 6'h3f;
    cur_n = (v == 0) ? 1 : (v > MAX_VERTICES) ? MAX_VERTICES : v;
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        // hold off long enough for the block to back up into its input
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        stall = pick_pause(recv_burst);
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d results pending",
             STALL_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_limits [9];
    int stop_at;
    phase_limits = '{2, 32, 1, 63, 9, 0, 33, 17, 0};
    phase_limits[8] = $urandom_range(0, 63);
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty graph lists every vertex with degree zero.
    send_cmd(OP_MAXDEG, 0, 63);
    send_cmd(OP_QUERY, 1, 2);
    send_cmd(OP_ADD, 1, 2);
    send_cmd(OP_QUERY, 2, 1);
    send_cmd(OP_ADD, 32, 32);        // self loop counts once
    send_cmd(OP_ADD, 0, 5);
    send_cmd(OP_ADD, 5, 33);
    send_cmd(OP_QUERY, 63, 63);
    send_cmd(OP_QUERY, 0, 0);
    send_cmd(OP_UNUSED, 21, 42);
    send_cmd(OP_ADD, 3, 1);
    send_cmd(OP_ADD, 1, 32);
    send_cmd(OP_MAXDEG, 63, 0);
    send_cmd(OP_QUERY, 32, 32);
    // Shrink: edges to high vertices stay stored but drop out of the scan.
    wait_idle();
    write_limit(4);
    send_cmd(OP_MAXDEG, 21, 42);
    send_cmd(OP_QUERY, 1, 32);
    send_cmd(OP_ADD, 4, 4);
    wait_idle();
    write_limit(0);
    send_cmd(OP_QUERY, 1, 1);
    send_cmd(OP_MAXDEG, 42, 21);
    send_cmd(OP_ADD, 1, 2);
    // Grow back: the stored high edges reappear.
    wait_idle();
    write_limit(63);
    send_cmd(OP_QUERY, 32, 1);
    send_cmd(OP_MAXDEG, 0, 0);

    foreach (phase_limits[p]) begin
      wait_idle();
      write_limit(phase_limits[p]);
      stop_at = commands_sent + PHASE_ITEMS;
      while (commands_sent < stop_at) begin
        if (p == 1 && commands_sent == stop_at - 40) long_hold = 1'b1;
        if (p == 1 && commands_sent == stop_at - 10) wait_idle();
        send_random();
      end
    end

    wait_idle();
    $display("Ran %0d commands and checked %0d results across %0d vertex-count settings,",
             commands_sent, checked, settings_used);
    $display("with random stalls on both streams and one long output hold-off.");
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fails);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
